FILE: hw/rtl/sose_pkg.sv
// ----------------------------------------------------------------------------
// sose_pkg
// Shared types and constants for the set-of-stacks engine: request and
// response payloads, operation codes, status codes and store geometry.
// ----------------------------------------------------------------------------
package sose_pkg;

	// Store geometry
	localparam int PLATE_CAP   = 3;
	localparam int PLATE_COUNT = 8;
	localparam int PLATE_W     = (PLATE_COUNT > 1) ? $clog2(PLATE_COUNT) : 1;
	localparam int SLOT_W      = (PLATE_CAP > 1) ? $clog2(PLATE_CAP) : 1;
	localparam int FILL_W      = $clog2(PLATE_CAP + 1);
	localparam int VALUE_W     = 32;

	// Operation codes
	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_POP_AT = 2'd2;

	// Response status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_REMOVED = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]                func;
		logic signed [VALUE_W-1:0] push_value;
		logic [2:0]                plate_index;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] pop_value;
		status_t                   status;
	} rsp_t;

endpackage

FILE: hw/rtl/set_of_stacks_engine_top.sv
// ----------------------------------------------------------------------------
// set_of_stacks_engine_top
// LIFO store split into fixed-size plates. Push, pop from top and pop from a
// named plate, with plate removal and shift-down, one response per request.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload | dir
//  --------+-----------+-----------+---------+-----
//  request | req_valid | req_stall | req     | in
//  response| rsp_valid | rsp_stall | rsp     | out
//
//  A request is registered, worked combinationally, and its response is
//  registered in the response register; one request per cycle is sustained
//  while the response side is not stalled.
//  The plate shift and state update sit between the request register and
//  the response register.
//  Reset clears all fill counts and the top plate; plate data is not cleared.
//  A stalled response holds the request register, which then stalls input.
// ----------------------------------------------------------------------------
module set_of_stacks_engine_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sose_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sose_pkg::rsp_t rsp
);
	import sose_pkg::*;

	// Request stage
	logic valid_s1;
	req_t req_s1;

	// Response stage
	logic rsp_valid_s2;
	rsp_t rsp_s2;

	// Store state
	logic [VALUE_W-1:0] store_q [PLATE_COUNT][PLATE_CAP];
	logic [FILL_W-1:0]  fill_q  [PLATE_COUNT];
	logic [PLATE_W-1:0] top_q;

	// Work signals
	logic               advance;
	logic [FILL_W-1:0]  fill_top;
	logic [FILL_W-1:0]  fill_idx;
	logic [FILL_W-1:0]  fill_below;
	logic [PLATE_W-1:0] idx;
	logic [PLATE_W-1:0] below;
	logic               wr_en;
	logic [PLATE_W-1:0] wr_plate;
	logic [FILL_W-1:0]  wr_fill;
	logic               take_en;
	logic [PLATE_W-1:0] take_plate;
	logic [SLOT_W-1:0]  take_slot;
	logic               shift_en;
	logic [PLATE_W-1:0] top_d;
	logic [FILL_W-1:0]  fill_d [PLATE_COUNT];
	status_t            status;
	logic [VALUE_W-1:0] rd_value;

	assign advance   = valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	assign idx        = req_s1.plate_index;
	assign below      = top_q - 1'b1;
	assign fill_top   = fill_q[top_q];
	assign fill_idx   = fill_q[idx];
	assign fill_below = fill_q[below];

	// Decode the operation into write, take and shift actions
	always_comb begin
		wr_en      = 1'b0;
		wr_plate   = top_q;
		wr_fill    = fill_top;
		take_en    = 1'b0;
		take_plate = top_q;
		shift_en   = 1'b0;
		top_d      = top_q;
		status     = ST_OK;
		unique case (req_s1.func)
			FUNC_PUSH: begin
				if (fill_top == FILL_W'(PLATE_CAP)) begin
					if (top_q == PLATE_W'(PLATE_COUNT - 1)) begin
						status = ST_FULL;
					end else begin
						// open the next plate, always empty above the top
						wr_en    = 1'b1;
						wr_plate = top_q + 1'b1;
						wr_fill  = '0;
						top_d    = top_q + 1'b1;
					end
				end else begin
					wr_en = 1'b1;
				end
			end
			FUNC_POP: begin
				if (fill_top == '0) begin
					if (top_q == '0) begin
						status = ST_EMPTY;
					end else begin
						// drop the empty top plate, take from the one below
						top_d = below;
						if (fill_below == '0) begin
							status = ST_EMPTY;
						end else begin
							take_en    = 1'b1;
							take_plate = below;
						end
					end
				end else begin
					take_en = 1'b1;
				end
			end
			FUNC_POP_AT: begin
				if (idx > top_q) begin
					status = ST_REMOVED;
				end else if (fill_idx != '0) begin
					take_en    = 1'b1;
					take_plate = idx;
				end else begin
					status = ST_REMOVED;
					if (top_q != '0) begin
						shift_en = 1'b1;
						top_d    = below;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Read of the value being removed
	assign take_slot = SLOT_W'(fill_q[take_plate] - 1'b1);
	assign rd_value  = store_q[take_plate][take_slot];

	// Next fill counts
	always_comb begin
		fill_d = fill_q;
		if (wr_en) begin
			fill_d[wr_plate] = wr_fill + 1'b1;
		end
		if (take_en) begin
			fill_d[take_plate] = fill_q[take_plate] - 1'b1;
		end
		if (shift_en) begin
			for (int p = 0; p < PLATE_COUNT - 1; p++) begin
				if (PLATE_W'(p) >= idx && PLATE_W'(p) < top_q) begin
					fill_d[p] = fill_q[p + 1];
				end
			end
			fill_d[top_q] = '0;
		end
	end

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Control state: fill counts and top plate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			for (int p = 0; p < PLATE_COUNT; p++) begin
				fill_q[p] <= '0;
			end
		end else if (advance) begin
			top_q  <= top_d;
			fill_q <= fill_d;
		end
	end

	// Plate data: shift down on removal, else write the pushed value
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int p = 0; p < PLATE_COUNT; p++) begin
				if (shift_en && p < PLATE_COUNT - 1 &&
				    PLATE_W'(p) >= idx && PLATE_W'(p) < top_q) begin
					store_q[p] <= store_q[(p < PLATE_COUNT - 1) ? p + 1 : p];
				end else if (wr_en && wr_plate == PLATE_W'(p)) begin
					store_q[p][SLOT_W'(wr_fill)] <= req_s1.push_value;
				end
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.pop_value <= take_en ? rd_value : '0;
			rsp_s2.status    <= status;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule

FILE: hw/rtl/sose_checker.sv
// ----------------------------------------------------------------------------
// sose_checker
// Port-level checks on the set-of-stacks engine, bound to the top level.
// ----------------------------------------------------------------------------
module sose_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sose_pkg::rsp_t rsp
);
	import sose_pkg::*;

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only a successful pop carries a value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.pop_value == '0)
		else $error("nonzero value with failing status");

	// Input is never stalled when the response side can move
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(rsp_valid && rsp_stall) |-> !req_stall)
		else $error("request stalled with free response slot");

	// A fresh response follows an accepted request
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("response without a request");

endmodule

bind set_of_stacks_engine_top sose_checker u_sose_checker (.*);
